[src/fbp_pkg.sv]
// shared types and constants for the fixed width bit packer
package fbp_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned ACC_W       = VALUE_WIDTH + BYTE_BITS;
  localparam int unsigned REM_W       = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] sample_value;
    logic                   last_value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 final_byte;
  } out_item_t;

  // classified item: value left aligned, effective width, last mark
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] aligned;
    logic [CFG_W-1:0]       width;
    logic                   last;
  } cmd_t;

endpackage

[src/fbp_front.sv]
// front end: width register, masking and alignment, command queue
module fbp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fbp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  fbp_pkg::in_item_t          in_item_i,
  output logic                       cmd_valid_o,
  output fbp_pkg::cmd_t              cmd_o,
  input  logic                       cmd_pop_i
);

  logic [fbp_pkg::CFG_W-1:0] width_q;
  fbp_pkg::cmd_t             mem_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                count_q;
  logic [fbp_pkg::CFG_W-1:0] eff_w;
  logic [fbp_pkg::CFG_W-1:0] shamt;
  fbp_pkg::cmd_t             new_cmd;
  logic                      do_push, do_pop;

  always_comb begin
    if (width_q > fbp_pkg::CFG_W'(fbp_pkg::VALUE_WIDTH)) begin
      eff_w = fbp_pkg::CFG_W'(fbp_pkg::VALUE_WIDTH);
    end else begin
      eff_w = width_q;
    end
    shamt            = fbp_pkg::CFG_W'(fbp_pkg::VALUE_WIDTH) - eff_w;
    new_cmd.aligned  = in_item_i.sample_value << shamt;
    new_cmd.width    = eff_w;
    new_cmd.last     = in_item_i.last_value;
  end

  assign full        = (count_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fbp_pkg::CFG_RESET;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

[src/fbp_back.sv]
// back end: bit accumulator, byte emission and output queue
module fbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  fbp_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output fbp_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW = fbp_pkg::ACC_W;
  localparam int unsigned BW = fbp_pkg::BYTE_BITS;

  logic                        busy_q, busy_d;
  logic [AW-1:0]               acc_q, acc_d;
  logic [fbp_pkg::REM_W-1:0]   rem_q, rem_d;
  logic                        last_q, last_d;
  logic [BW-1:0]               pbits_q, pbits_d;
  logic [fbp_pkg::CNT_W-1:0]   pcnt_q, pcnt_d;

  fbp_pkg::out_item_t          oq_q [2];
  logic                        owr_q, ord_q;
  logic [1:0]                  ocnt_q;

  logic                        out_ready, want_emit, emit, stall, item_done, free, load;
  logic [AW-1:0]               acc_a;
  logic [fbp_pkg::REM_W-1:0]   rem_a;
  logic [BW-1:0]               pb;
  logic [fbp_pkg::CNT_W-1:0]   pc;
  fbp_pkg::out_item_t          emit_item;
  logic                        opop;

  assign out_ready = (ocnt_q != 2'd2);

  always_comb begin
    want_emit = busy_q && ((rem_q >= fbp_pkg::REM_W'(BW)) ||
                           (last_q && (rem_q != '0)));
    emit      = want_emit && out_ready;
    stall     = want_emit && !out_ready;

    emit_item.packed_byte = acc_q[AW-1 -: BW];
    emit_item.final_byte  = last_q && (rem_q <= fbp_pkg::REM_W'(BW));

    if (emit) begin
      acc_a = acc_q << BW;
      if (rem_q >= fbp_pkg::REM_W'(BW)) begin
        rem_a = rem_q - fbp_pkg::REM_W'(BW);
      end else begin
        rem_a = '0;
      end
    end else begin
      acc_a = acc_q;
      rem_a = rem_q;
    end

    item_done = busy_q && !stall && (rem_a < fbp_pkg::REM_W'(BW)) &&
                !(last_q && (rem_a != '0));
    free      = !busy_q || item_done;

    if (item_done) begin
      pb = last_q ? '0 : acc_a[AW-1 -: BW];
      pc = last_q ? '0 : rem_a[fbp_pkg::CNT_W-1:0];
    end else begin
      pb = pbits_q;
      pc = pcnt_q;
    end

    load      = free && cmd_valid_i;
    cmd_pop_o = load;

    busy_d  = busy_q;
    acc_d   = acc_a;
    rem_d   = rem_a;
    last_d  = last_q;
    pbits_d = pb;
    pcnt_d  = pc;
    if (load) begin
      busy_d = 1'b1;
      acc_d  = {pb, {fbp_pkg::VALUE_WIDTH{1'b0}}} |
               ({cmd_i.aligned, {BW{1'b0}}} >> pc);
      rem_d  = fbp_pkg::REM_W'(pc) + cmd_i.width;
      last_d = cmd_i.last;
    end else if (item_done) begin
      busy_d = 1'b0;
    end
  end

  assign empty      = (ocnt_q == 2'd0);
  assign opop       = pop && !empty;
  assign out_item_o = oq_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      last_q  <= 1'b0;
      pbits_q <= '0;
      pcnt_q  <= '0;
      rem_q   <= '0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      busy_q  <= busy_d;
      last_q  <= last_d;
      pbits_q <= pbits_d;
      pcnt_q  <= pcnt_d;
      rem_q   <= rem_d;
      if (emit) begin
        owr_q <= ~owr_q;
      end
      if (opop) begin
        ord_q <= ~ord_q;
      end
      if (emit && !opop) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (opop && !emit) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (emit) begin
      oq_q[owr_q] <= emit_item;
    end
  end

endmodule

[src/fixed_width_bit_packer_top.sv]
// fixed width bit packer: values cut to a set width, packed msb first into bytes
// path: an item passes the command queue, the bit accumulator and the output queue
// throughput: one byte per cycle while the output queue is not full, and values
//   of under 8 bits go through at one per cycle; set by the byte output port
// reset: width register returns to 8, partial byte and both queues are cleared
module fixed_width_bit_packer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fbp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  fbp_pkg::in_item_t          in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output fbp_pkg::out_item_t         out_item_o
);

  logic          cmd_valid, cmd_pop;
  fbp_pkg::cmd_t cmd;

  fbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule
